// File: hw/rtl/angle_range_clip_set_defines.svh
// assertion macros for the angle range clip set checker
`ifndef ANGLE_RANGE_CLIP_SET_DEFINES_SVH
`define ANGLE_RANGE_CLIP_SET_DEFINES_SVH

// same-cycle implication
`define ARCS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("arcs check failed");

// next-cycle implication
`define ARCS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("arcs check failed");

`endif

// File: hw/rtl/arcs_pkg.sv
// shared types and constants of the angle range clip set
`default_nettype none
package arcs_pkg;
    localparam int OP_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD         = 2'd0,
        OP_CHECK_RANGE = 2'd1,
        OP_CHECK_ANGLE = 2'd2,
        OP_CLEAR       = 2'd3
    } t_op;
endpackage
`default_nettype wire

// File: hw/rtl/arcs_bank.sv
// one bank of range storage: synchronous ram, one write and one registered read port
`default_nettype none
module arcs_bank #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule
`default_nettype wire

// File: hw/rtl/angle_range_clip_set.sv
// angle range clip set: sorted disjoint angle ranges kept in two ping-pong ram banks
//
// input channel: i_valid / o_stall carries operation, start and end angle.
// output channel: o_valid / i_stall carries visible, full_res and overflow, one
// result beat per input beat, held in an output register until taken.
// config channel: i_cfg_valid / o_cfg_ready writes disable_culling; always ready.
// one item is worked at a time; o_stall is high from acceptance until the result
// is loaded into the output register.
// clear goes straight to the finishing state; a check scans the stored ranges once.
// an add part scans the bank and, when the set changes, streams it into the other
// bank, with an extra write for an insertion; a wrapping add runs two parts.
// each scan reads one entry at a time through the bank's registered read port,
// alternating a read state and a process state per entry.
// reset empties the set and clears disable_culling; no clearing pass is needed
// since entries at or above the count are never read.
// a stalled receiver holds the result; a new item may be taken meanwhile, and
// its result waits in the finishing state until the register is free.
`default_nettype none
module angle_range_clip_set #(
    parameter int MAX_RANGES = 64,
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [arcs_pkg::OP_W-1:0]   i_operation,
    input  wire logic [ANGLE_BITS-1:0]       i_start_angle,
    input  wire logic [ANGLE_BITS-1:0]       i_end_angle,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic                             o_visible,
    output logic                             o_full_res,
    output logic                             o_overflow,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic                        i_cfg_data
);
    import arcs_pkg::*;

    localparam int IW = $clog2(MAX_RANGES);
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int DW = 2 * ANGLE_BITS;
    localparam logic [ANGLE_BITS-1:0] ANG_TOP = {ANGLE_BITS{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE, ST_S_RD, ST_S_PROC, ST_PLAN, ST_W_RD, ST_W_PROC, ST_W_INS, ST_DONE
    } t_state;

    t_state r_state;
    t_op    r_op;
    logic   r_bank, r_dis, r_wrap, r_part2;
    logic [CW-1:0] r_count, r_k, r_w, r_fcnt, r_pos, r_hit_k;
    logic [ANGLE_BITS-1:0] r_s, r_e, r_ps, r_pe, r_fuse_end;
    logic r_cov, r_covb, r_ang, r_hit, r_hit_end, r_need_next, r_fuse;
    logic r_skip, r_ins_done, r_need_ins, r_ovf, r_first_full;
    logic r_out_valid, r_vis, r_full, r_ovf_o;

    logic [DW-1:0] q0, q1, rdata, wdata;
    logic [ANGLE_BITS-1:0] ds, de;
    logic re, we, ins_now, cov_a, cov_b, ang_in, enclosed;

    assign rdata = r_bank ? q1 : q0;
    assign ds = rdata[DW-1:ANGLE_BITS];
    assign de = rdata[ANGLE_BITS-1:0];

    assign cov_a    = (r_ps >= ds) && (r_pe <= de);
    assign cov_b    = (ds == '0) && (r_e <= de);
    assign ang_in   = (r_s > ds) && (r_s < de);
    assign enclosed = (ds >= r_ps) && (de <= r_pe);

    assign re = ((r_state == ST_S_RD) || (r_state == ST_W_RD)) && (r_k != r_count);
    assign ins_now = (r_state == ST_W_PROC) && !enclosed && !r_skip && r_need_ins
                     && !r_ins_done && (r_w == r_pos);

    always_comb begin
        we = 1'b0;
        wdata = rdata;
        if (r_state == ST_W_INS || ins_now) begin
            we = 1'b1;
            wdata = {r_ps, r_pe};
        end else if (r_state == ST_W_PROC && !enclosed && !r_skip) begin
            we = 1'b1;
            if (r_hit && r_k == r_hit_k) begin
                if (r_hit_end) begin
                    wdata = {ds, (r_fuse ? r_fuse_end : r_pe)};
                end else begin
                    wdata = {r_ps, de};
                end
            end
        end
    end

    arcs_bank #(.DEPTH(MAX_RANGES), .WIDTH(DW)) u_bank0 (
        .i_clk(i_clk), .i_we(we && r_bank), .i_waddr(r_w[IW-1:0]), .i_wdata(wdata),
        .i_re(re), .i_raddr(r_k[IW-1:0]), .o_rdata(q0)
    );
    arcs_bank #(.DEPTH(MAX_RANGES), .WIDTH(DW)) u_bank1 (
        .i_clk(i_clk), .i_we(we && !r_bank), .i_waddr(r_w[IW-1:0]), .i_wdata(wdata),
        .i_re(re), .i_raddr(r_k[IW-1:0]), .o_rdata(q1)
    );

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_visible   = r_vis;
    assign o_full_res  = r_full;
    assign o_overflow  = r_ovf_o;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_bank       <= 1'b0;
            r_count      <= '0;
            r_dis        <= 1'b0;
            r_first_full <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_dis <= i_cfg_data;
            end
            if (r_out_valid && !i_stall && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            if (we && r_w == '0) begin
                r_first_full <= (wdata[DW-1:ANGLE_BITS] == '0)
                                && (wdata[ANGLE_BITS-1:0] == ANG_TOP);
            end
            if (we) begin
                r_w <= r_w + CW'(1);
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_op    <= t_op'(i_operation);
                        r_s     <= i_start_angle;
                        r_e     <= i_end_angle;
                        r_ps    <= i_start_angle;
                        r_pe    <= (i_start_angle > i_end_angle) ? ANG_TOP : i_end_angle;
                        r_wrap  <= (i_start_angle > i_end_angle);
                        r_part2 <= 1'b0;
                        r_ovf   <= 1'b0;
                        r_k <= '0; r_fcnt <= '0; r_pos <= '0;
                        r_cov <= 1'b0; r_covb <= 1'b0; r_ang <= 1'b0;
                        r_hit <= 1'b0; r_need_next <= 1'b0; r_fuse <= 1'b0;
                        if (t_op'(i_operation) == OP_CLEAR) begin
                            r_count      <= '0;
                            r_first_full <= 1'b0;
                            r_state      <= ST_DONE;
                        end else begin
                            r_state <= ST_S_RD;
                        end
                    end
                end
                ST_S_RD: begin
                    r_state <= (r_k == r_count) ? ST_PLAN : ST_S_PROC;
                end
                ST_S_PROC: begin
                    r_cov  <= r_cov | cov_a;
                    r_covb <= r_covb | cov_b;
                    r_ang  <= r_ang | ang_in;
                    if (!enclosed) begin
                        r_fcnt <= r_fcnt + CW'(1);
                        if (r_need_next) begin
                            r_need_next <= 1'b0;
                            r_fuse      <= (ds <= r_pe);
                            r_fuse_end  <= de;
                        end else if (!r_hit) begin
                            if (ds < r_pe) begin
                                r_pos <= r_fcnt + CW'(1);
                            end
                            if (ds >= r_ps && ds <= r_pe) begin
                                r_hit <= 1'b1; r_hit_end <= 1'b0; r_hit_k <= r_k;
                            end else if (de >= r_ps && de <= r_pe) begin
                                r_hit <= 1'b1; r_hit_end <= 1'b1; r_hit_k <= r_k;
                                r_need_next <= 1'b1;
                            end
                        end
                    end
                    r_k     <= r_k + CW'(1);
                    r_state <= ST_S_RD;
                end
                ST_PLAN: begin
                    if (r_op != OP_ADD) begin
                        r_state <= ST_DONE;
                    end else if (r_cov || (!r_hit && r_fcnt >= CW'(MAX_RANGES))) begin
                        // covered or no room: set unchanged
                        if (!r_cov) begin
                            r_ovf <= 1'b1;
                        end
                        if (r_wrap && !r_part2) begin
                            r_part2 <= 1'b1; r_ps <= '0; r_pe <= r_e;
                            r_k <= '0; r_fcnt <= '0; r_pos <= '0;
                            r_cov <= 1'b0; r_hit <= 1'b0; r_need_next <= 1'b0;
                            r_fuse <= 1'b0;
                            r_state <= ST_S_RD;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end else begin
                        r_need_ins   <= !r_hit;
                        r_ins_done   <= 1'b0;
                        r_skip       <= 1'b0;
                        r_k          <= '0;
                        r_w          <= '0;
                        r_first_full <= 1'b0;
                        r_state      <= ST_W_RD;
                    end
                end
                ST_W_RD: begin
                    if (r_k != r_count) begin
                        r_state <= ST_W_PROC;
                    end else if (r_need_ins && !r_ins_done) begin
                        r_state <= ST_W_INS;
                    end else begin
                        r_count <= r_w;
                        r_bank  <= ~r_bank;
                        if (r_wrap && !r_part2) begin
                            r_part2 <= 1'b1; r_ps <= '0; r_pe <= r_e;
                            r_k <= '0; r_fcnt <= '0; r_pos <= '0;
                            r_cov <= 1'b0; r_hit <= 1'b0; r_need_next <= 1'b0;
                            r_fuse <= 1'b0;
                            r_state <= ST_S_RD;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_W_PROC: begin
                    if (ins_now) begin
                        // new element written in this cycle; state and read data hold for the current entry
                        r_ins_done <= 1'b1;
                    end else begin
                        if (!enclosed) begin
                            if (r_skip) begin
                                r_skip <= 1'b0;
                            end else if (r_hit && r_hit_end && r_k == r_hit_k && r_fuse) begin
                                r_skip <= 1'b1;
                            end
                        end
                        r_k     <= r_k + CW'(1);
                        r_state <= ST_W_RD;
                    end
                end
                ST_W_INS: begin
                    r_ins_done <= 1'b1;
                    r_state    <= ST_W_RD;
                end
                ST_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_full      <= !r_dis && r_first_full;
                        r_ovf_o     <= (r_op == OP_ADD) && r_ovf;
                        case (r_op)
                            OP_CHECK_RANGE: r_vis <= r_dis
                                || (r_wrap ? !(r_cov && r_covb) : !r_cov);
                            OP_CHECK_ANGLE: r_vis <= r_dis || !r_ang;
                            default:        r_vis <= 1'b0;
                        endcase
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/arcs_check.sv
// port-level checker for the angle range clip set, bound to the top level
`default_nettype none
`include "angle_range_clip_set_defines.svh"
module arcs_check #(
    parameter int ANGLE_BITS = 16
) (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_valid,
    input wire logic                      o_stall,
    input wire logic [arcs_pkg::OP_W-1:0] i_operation,
    input wire logic [ANGLE_BITS-1:0]     i_start_angle,
    input wire logic [ANGLE_BITS-1:0]     i_end_angle,
    input wire logic                      o_valid,
    input wire logic                      i_stall,
    input wire logic                      o_visible,
    input wire logic                      o_full_res,
    input wire logic                      o_overflow,
    input wire logic                      i_cfg_valid,
    input wire logic                      o_cfg_ready,
    input wire logic                      i_cfg_data
);
    import arcs_pkg::*;

    // a held result beat keeps its payload
    `ARCS_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable({o_visible, o_full_res, o_overflow}))
    // only adds flag overflow and they never report visible
    `ARCS_ASSERT_NOW(a_vis_ovf, o_valid, !(o_visible && o_overflow))
    // one item at a time: busy right after an accepted beat
    `ARCS_ASSERT_NEXT(a_busy, i_valid && !o_stall, o_stall)
    // a stalled input beat keeps its payload
    `ARCS_ASSERT_NEXT(a_in_hold, i_valid && o_stall, i_valid && $stable({i_operation, i_start_angle, i_end_angle}))
    // config beats arrive only while the block is empty
    `ARCS_ASSERT_NOW(a_cfg_idle, i_cfg_valid && o_cfg_ready, !o_stall && !o_valid && !$isunknown(i_cfg_data))
endmodule

bind angle_range_clip_set arcs_check #(.ANGLE_BITS(ANGLE_BITS)) u_arcs_check (.*);
`default_nettype wire

// File: bench/tb_angle_range_clip_set.sv
// testbench for angle_range_clip_set: directed and random operations checked against a predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_angle_range_clip_set;
    import arcs_pkg::*;

    localparam int N_RANGES = 64;
    localparam int AMAX = 65535;

    typedef struct packed {
        logic visible;
        logic full_res;
        logic overflow;
    } t_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [OP_W-1:0] i_operation = OP_ADD;
    logic [15:0] i_start_angle = '0;
    logic [15:0] i_end_angle = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic o_visible;
    logic o_full_res;
    logic o_overflow;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_data = 1'b0;

    angle_range_clip_set #(.MAX_RANGES(N_RANGES), .ANGLE_BITS(16)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_operation(i_operation), .i_start_angle(i_start_angle),
        .i_end_angle(i_end_angle),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_visible(o_visible), .o_full_res(o_full_res), .o_overflow(o_overflow),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the range table
    int unsigned arc_lo [N_RANGES];
    int unsigned arc_hi [N_RANGES];
    int unsigned arc_count = 0;
    logic culling_off = 1'b0;

    t_result pending_q[$];
    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int overflows_seen = 0;
    int fulls_seen = 0;
    int hold_cycles = 0;
    int hold_starts = 0;
    int hold_taken = 0;

    function automatic void remove_arc(int unsigned i);
        for (int unsigned k = i; k + 1 < arc_count; k++) begin
            arc_lo[k] = arc_lo[k+1];
            arc_hi[k] = arc_hi[k+1];
        end
        if (arc_count > 0) arc_count--;
    endfunction

    // returns 1 when the part could not be stored
    function automatic bit merge_arc(int unsigned s, int unsigned e);
        int unsigned i;
        int unsigned pos;
        pos = 0;
        for (i = 0; i < arc_count; i++)
            if (s >= arc_lo[i] && e <= arc_hi[i]) return 1'b0;
        i = 0;
        while (i < arc_count) begin
            if (arc_lo[i] >= s && arc_hi[i] <= e) remove_arc(i);
            else i++;
        end
        for (i = 0; i < arc_count; i++) begin
            if (arc_lo[i] < e) pos = i + 1;
            if (arc_lo[i] >= s && arc_lo[i] <= e) begin
                arc_lo[i] = s;
                return 1'b0;
            end
            if (arc_hi[i] >= s && arc_hi[i] <= e) begin
                // part bridges two neighbours
                if (i + 1 < arc_count && arc_lo[i+1] <= e) begin
                    arc_hi[i] = arc_hi[i+1];
                    remove_arc(i + 1);
                end else begin
                    arc_hi[i] = e;
                end
                return 1'b0;
            end
        end
        if (arc_count >= N_RANGES) return 1'b1;
        for (i = arc_count; i > pos; i--) begin
            arc_lo[i] = arc_lo[i-1];
            arc_hi[i] = arc_hi[i-1];
        end
        arc_lo[pos] = s;
        arc_hi[pos] = e;
        arc_count++;
        return 1'b0;
    endfunction

    function automatic bit span_open(int unsigned s, int unsigned e);
        for (int unsigned i = 0; i < arc_count; i++)
            if (s >= arc_lo[i] && e <= arc_hi[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit angle_open(int unsigned a);
        for (int unsigned i = 0; i < arc_count; i++)
            if (a > arc_lo[i] && a < arc_hi[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_result predict_clip(t_op op, int unsigned s, int unsigned e);
        t_result r;
        bit a;
        bit b;
        r = '0;
        case (op)
            OP_ADD: begin
                if (s > e) begin
                    a = merge_arc(s, AMAX);
                    b = merge_arc(0, e);
                    r.overflow = a | b;
                end else begin
                    r.overflow = merge_arc(s, e);
                end
            end
            OP_CHECK_RANGE: begin
                if (culling_off) r.visible = 1'b1;
                else if (s > e) r.visible = span_open(s, AMAX) | span_open(0, e);
                else r.visible = span_open(s, e);
            end
            OP_CHECK_ANGLE: r.visible = culling_off ? 1'b1 : angle_open(s);
            default: arc_count = 0;
        endcase
        r.full_res = !culling_off && arc_count > 0 && arc_lo[0] == 0 && arc_hi[0] == AMAX;
        return r;
    endfunction

    // receiver stall: random, or forced high while a hold-off runs
    always @(negedge i_clk) begin
        if (hold_starts != hold_taken) begin
            hold_taken <= hold_starts;
            hold_cycles <= 599;
            i_stall <= 1'b1;
        end else if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if ($urandom_range(0, 99) < 25) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_q.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (o_visible !== want.visible) begin
                    $error("visible: expected %0b actual %0b", want.visible, o_visible);
                    errors++;
                end
                if (o_full_res !== want.full_res) begin
                    $error("full_res: expected %0b actual %0b", want.full_res, o_full_res);
                    errors++;
                end
                if (o_overflow !== want.overflow) begin
                    $error("overflow: expected %0b actual %0b", want.overflow, o_overflow);
                    errors++;
                end
                if (want.overflow) overflows_seen++;
                if (want.full_res) fulls_seen++;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // called at a falling edge; returns at a falling edge
    task automatic send_op(t_op op, int unsigned s, int unsigned e, bit no_gap = 1'b0);
        int gap;
        i_valid <= 1'b1;
        i_operation <= op;
        i_start_angle <= s[15:0];
        i_end_angle <= e[15:0];
        do @(posedge i_clk); while (o_stall);
        pending_q.push_back(predict_clip(op, s, e));
        items_sent++;
        @(negedge i_clk);
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        if (i_valid) i_valid <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_culling(bit v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        culling_off = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_op(OP_ADD, 0, 0);
        send_op(OP_CHECK_ANGLE, 0, 0);
        send_op(OP_CHECK_RANGE, 0, 0);
        send_op(OP_ADD, AMAX, AMAX);
        send_op(OP_ADD, 100, 200);
        send_op(OP_ADD, 300, 400);
        send_op(OP_ADD, 120, 180);
        send_op(OP_ADD, 150, 350);
        send_op(OP_CHECK_ANGLE, 100, 0);
        send_op(OP_CHECK_ANGLE, 101, 0);
        send_op(OP_CHECK_RANGE, 100, 400);
        send_op(OP_ADD, 60000, 50);
        send_op(OP_CHECK_RANGE, 65000, 10);
        send_op(OP_CHECK_RANGE, 65000, 120);
        send_op(OP_ADD, 500, 1000);
        send_op(OP_ADD, 0, AMAX);
        send_op(OP_CHECK_RANGE, 0, AMAX);
        send_op(OP_CHECK_ANGLE, 32768, 0);
        write_culling(1'b1);
        send_op(OP_CHECK_RANGE, 5, 6);
        send_op(OP_CHECK_ANGLE, AMAX, AMAX);
        send_op(OP_CLEAR, AMAX, 0);
        write_culling(1'b0);
        send_op(OP_CHECK_ANGLE, 32768, AMAX);
        send_op(OP_CLEAR, 0, 0);
    endtask

    // fill every slot, then try one more insertion and a merge at a full table
    task automatic test_overflow();
        for (int k = 0; k < N_RANGES; k++) send_op(OP_ADD, k * 1000 + 10, k * 1000 + 20);
        send_op(OP_ADD, 64500, 64600);
        send_op(OP_ADD, 64990, 5);
        send_op(OP_ADD, 15, 30);
        send_op(OP_CHECK_RANGE, 1015, 1018);
        send_op(OP_CLEAR, 0, 0);
    endtask

    task automatic random_op();
        int r;
        int unsigned s;
        int unsigned e;
        r = $urandom_range(0, 99);
        s = $urandom_range(0, AMAX);
        e = ($urandom_range(0, 9) == 0) ? $urandom_range(0, AMAX)
                                         : (s + $urandom_range(0, 3000)) % 65536;
        if (r < 40) send_op(OP_ADD, s, e);
        else if (r < 68) send_op(OP_CHECK_RANGE, s, e);
        else if (r < 96) send_op(OP_CHECK_ANGLE, s, e);
        else send_op(OP_CLEAR, s, e);
    endtask

    task automatic test_random(int n);
        for (int k = 0; k < n; k++) random_op();
    endtask

    // receiver holds off while the sender keeps offering beats back to back
    task automatic test_backpressure();
        drain();
        hold_starts++;
        for (int k = 0; k < 12; k++) send_op(OP_CHECK_ANGLE, $urandom_range(0, AMAX), 0, 1'b1);
        drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_overflow();
        test_random(350);
        write_culling(1'b1);
        test_random(150);
        write_culling(1'b0);
        test_backpressure();
        test_random(550);
        drain();
        repeat (600) @(negedge i_clk);
        $display("ran %0d items, %0d results checked", items_sent, results_seen);
        $display("overflow results %0d, full results %0d, culling toggled on and off",
                 overflows_seen, fulls_seen);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("tb_angle_range_clip_set passed");
        end else begin
            $display("tb_angle_range_clip_set failed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("tb_angle_range_clip_set failed");
        $finish;
    end
endmodule
`default_nettype wire
